@@ rtl/sha256sh_pkg.sv @@
// Shared types, round constants and bit functions of the SHA-256 stream hasher.
// No dependencies; the top level takes everything here by scoped names.
package sha256sh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_START   = 6'd56;
  localparam logic [5:0] LAST_BYTE   = 6'd63;
  localparam logic [5:0] LOAD_LAST   = 6'd16;
  localparam logic [5:0] ROUND_LAST  = 6'd63;
  localparam logic [2:0] LAST_WORD   = 3'd7;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ rtl/sha256_stream_hasher_unit.sv @@
// SHA-256 stream hasher: data beats of one byte in, eight digest-word beats out per finish.
// A data byte is written into the block buffer; every 64th byte starts a block compression.
// A finish beat pads 9 to 72 bytes, one per cycle, with one or two compressions, and the
// digest words then follow, one word per unstalled cycle.
// Input stalls outside idle: while padding, compressing on the single shared round unit, or emitting.
// Reset (rst, synchronous) restores the initial hash; the buffer is not cleared. Needs sha256sh_pkg.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);

  // Control state.
  sha256sh_pkg::state_t state, state_next;
  logic [5:0]  fill;        // bytes held in the current block
  logic [63:0] byte_total;  // message bytes seen so far
  logic [5:0]  cnt;         // load and round counter
  logic [2:0]  eidx;        // digest word being emitted
  logic        fin;         // a finish beat is being processed
  logic        pad_first;   // next pad byte is the 0x80 marker
  logic        len_ok;      // the length field fits in the current block
  logic        emit_after;  // the block being compressed is the final one

  // Datapath.
  logic [31:0] h [8];       // chaining state
  logic [31:0] v [8];       // working variables a..h
  logic [31:0] w [16];      // message schedule window, w[0] is the current round's word
  logic [63:0] len_sh;      // message length in bits, shifted out a byte at a time
  logic [23:0] acc;         // bytes of the word being assembled

  // The block buffer: sixteen 32-bit words, one write port, one registered read port.
  logic [31:0] blk_mem [16];
  logic [31:0] rd_data;

  logic        accept_in;
  logic        byte_we;
  logic [7:0]  byte_val;
  logic        mem_we;
  logic        len_ok_new;
  logic [31:0] t1, t2, w_new;

  assign accept_in = item_valid && (state == sha256sh_pkg::ST_IDLE);
  assign item_stall = (state != sha256sh_pkg::ST_IDLE);

  // Both the data beats and the padding sequencer write through the same byte path, so the
  // padded block lands in the buffer exactly as message bytes would.
  always_comb begin
    state_next = state;
    byte_we = 1'b0;
    byte_val = data_byte;
    case (state)
      sha256sh_pkg::ST_IDLE: begin
        if (accept_in) begin
          if (kind == 1'b0) begin
            byte_we = 1'b1;
            if (fill == sha256sh_pkg::LAST_BYTE) begin
              state_next = sha256sh_pkg::ST_LOAD;
            end
          end else begin
            state_next = sha256sh_pkg::ST_PAD;
          end
        end
      end
      sha256sh_pkg::ST_PAD: begin
        byte_we = 1'b1;
        if (pad_first) begin
          byte_val = sha256sh_pkg::PAD_MARK;
        end else if (len_ok && (fill >= sha256sh_pkg::LEN_START)) begin
          byte_val = len_sh[63:56];
        end else begin
          byte_val = 8'h00;
        end
        if (fill == sha256sh_pkg::LAST_BYTE) begin
          state_next = sha256sh_pkg::ST_LOAD;
        end
      end
      sha256sh_pkg::ST_LOAD: begin
        if (cnt == sha256sh_pkg::LOAD_LAST) begin
          state_next = sha256sh_pkg::ST_ROUND;
        end
      end
      sha256sh_pkg::ST_ROUND: begin
        if (cnt == sha256sh_pkg::ROUND_LAST) begin
          state_next = sha256sh_pkg::ST_ADD;
        end
      end
      sha256sh_pkg::ST_ADD: begin
        if (!fin) begin
          state_next = sha256sh_pkg::ST_IDLE;
        end else if (emit_after) begin
          state_next = sha256sh_pkg::ST_EMIT;
        end else begin
          state_next = sha256sh_pkg::ST_PAD;
        end
      end
      sha256sh_pkg::ST_EMIT: begin
        if (!result_stall && (eidx == sha256sh_pkg::LAST_WORD)) begin
          state_next = sha256sh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sha256sh_pkg::ST_IDLE;
      end
    endcase
  end

  assign mem_we = byte_we && (fill[1:0] == 2'd3);
  assign len_ok_new = pad_first ? (fill < sha256sh_pkg::LEN_START) : len_ok;

  // One compression round and one schedule extension per cycle.
  assign t1 = v[7] + sha256sh_pkg::big_sigma1(v[4]) + sha256sh_pkg::choose(v[4], v[5], v[6])
            + sha256sh_pkg::ROUND_K[cnt] + w[0];
  assign t2 = sha256sh_pkg::big_sigma0(v[0]) + sha256sh_pkg::majority(v[0], v[1], v[2]);
  assign w_new = sha256sh_pkg::small_sigma1(w[14]) + w[9] + sha256sh_pkg::small_sigma0(w[1])
               + w[0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[fill[5:2]] <= {acc, byte_val};
    end
    rd_data <= blk_mem[cnt[3:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256sh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      byte_total <= '0;
      cnt <= '0;
      eidx <= '0;
      fin <= 1'b0;
      pad_first <= 1'b0;
      len_ok <= 1'b0;
      emit_after <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= sha256sh_pkg::INIT_HASH[i];
      end
    end else begin
      if (byte_we) begin
        acc <= {acc[15:0], byte_val};
        fill <= fill + 6'd1;
      end

      if (accept_in && (kind == 1'b0)) begin
        byte_total <= byte_total + 64'd1;
      end

      // A finish beat latches the bit length and starts the padding sequence.
      if (accept_in && (kind == 1'b1)) begin
        fin <= 1'b1;
        pad_first <= 1'b1;
        len_ok <= 1'b0;
        emit_after <= 1'b0;
        len_sh <= {byte_total[60:0], 3'b000};
        byte_total <= '0;
      end

      if (state == sha256sh_pkg::ST_PAD) begin
        pad_first <= 1'b0;
        // At the end of a block either the length went in, or the next block carries it.
        len_ok <= len_ok_new || (fill == sha256sh_pkg::LAST_BYTE);
        if (!pad_first && len_ok && (fill >= sha256sh_pkg::LEN_START)) begin
          len_sh <= {len_sh[55:0], 8'h00};
        end
        if ((fill == sha256sh_pkg::LAST_BYTE) && len_ok_new) begin
          emit_after <= 1'b1;
        end
      end

      if ((state_next == sha256sh_pkg::ST_LOAD) && (state != sha256sh_pkg::ST_LOAD)) begin
        cnt <= '0;
        for (int i = 0; i < 8; i++) begin
          v[i] <= h[i];
        end
      end

      // The read issued at count n returns at count n + 1 and shifts into the window.
      if (state == sha256sh_pkg::ST_LOAD) begin
        if (cnt != 6'd0) begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i + 1];
          end
          w[15] <= rd_data;
        end
        if (cnt == sha256sh_pkg::LOAD_LAST) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end

      if (state == sha256sh_pkg::ST_ROUND) begin
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i + 1];
        end
        w[15] <= w_new;
        cnt <= cnt + 6'd1;
      end

      if (state == sha256sh_pkg::ST_ADD) begin
        for (int i = 0; i < 8; i++) begin
          h[i] <= h[i] + v[i];
        end
        eidx <= '0;
      end

      // After the eighth digest beat the hasher is back in its initial state.
      if ((state == sha256sh_pkg::ST_EMIT) && !result_stall) begin
        eidx <= eidx + 3'd1;
        if (eidx == sha256sh_pkg::LAST_WORD) begin
          fin <= 1'b0;
          emit_after <= 1'b0;
          len_ok <= 1'b0;
          for (int i = 0; i < 8; i++) begin
            h[i] <= sha256sh_pkg::INIT_HASH[i];
          end
        end
      end
    end
  end

  assign result_valid = (state == sha256sh_pkg::ST_EMIT);
  assign digest_word = h[eidx];
  assign word_index = eidx;
  assign last = (eidx == sha256sh_pkg::LAST_WORD);

endmodule

@@ tb/sv/tb_sha256_stream_hasher_unit.sv @@
// Self-checking testbench for sha256_stream_hasher_unit: byte beats in, digest words out.
// Holds its own SHA-256 predictor and compares every digest beat field by field.
// Needs only the RTL of the hasher and its package.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_unit;

  // Input beat kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam int  TARGET_BEATS = 250;  // stimulus stops once this many beats are queued
  localparam int  TAIL_CYCLES  = 400;  // two compressions plus padding, with margin
  localparam int  DIGEST_WORDS = 8;

  // Round constants and initial chaining value, kept locally so the prediction does not
  // lean on the tables inside the design.
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One beat waiting to be sent. A beat marked hold is not offered until every digest
  // word owed so far has been taken; steady beats are sent with no idle gap after them.
  typedef struct {
    logic       kind;
    logic [7:0] value;
    bit         hold;
    bit         steady;
  } send_beat_t;

  // One expected digest beat.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  logic        kind         = KIND_DATA;
  logic [7:0]  data_byte    = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  sha256_stream_hasher_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last         (last)
  );

  always #1 clk = ~clk;

  // Predictor state: chaining words, the partial block, how many bytes it holds, and the
  // running message length in bytes (wraps at 64 bits like the hardware counter).
  logic [31:0] hash_chain [8];
  logic [7:0]  block_buf  [64];
  logic [5:0]  buf_fill;
  logic [63:0] msg_bytes;

  send_beat_t   send_q[$];
  digest_beat_t digest_q[$];

  // Digest words owed by accepted finish beats and digest words taken so far. Both are
  // written with nonblocking assignments, so the hold check in the driver reads stable values.
  int unsigned words_owed = 0;
  int unsigned words_seen = 0;
  int unsigned fails      = 0;

  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  bit          recv_steady = 1'b0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int j = 0; j < 8; j++) hash_chain[j] = SHA_IV[j];
    for (int j = 0; j < 64; j++) block_buf[j] = 8'h00;
    buf_fill  = '0;
    msg_bytes = '0;
  endfunction

  // Runs the 64 rounds over block_buf and folds the result into hash_chain.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    for (int j = 0; j < 16; j++)
      w[j] = {block_buf[4*j], block_buf[4*j+1], block_buf[4*j+2], block_buf[4*j+3]};
    for (int j = 16; j < 64; j++) begin
      s0   = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
      s1   = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = s1 + w[j-7] + s0 + w[j-16];
    end
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (int j = 0; j < 64; j++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[j] + w[j];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
  endfunction

  // Applies one accepted beat to the predictor. A finish beat pads the message, queues the
  // eight expected digest words and starts a fresh message.
  function automatic void absorb_beat(logic k, logic [7:0] v);
    int          pos;
    logic [63:0] bit_len;
    if (k == KIND_DATA) begin
      block_buf[buf_fill] = v;
      buf_fill  = buf_fill + 6'd1;
      msg_bytes = msg_bytes + 64'd1;
      if (buf_fill == 6'd0) compress_block();
    end else begin
      bit_len = msg_bytes << 3;
      pos = buf_fill;
      block_buf[pos] = 8'h80;
      pos = pos + 1;
      // No room left for the length field: close this block and pad a second one.
      if (pos > 56) begin
        while (pos < 64) begin
          block_buf[pos] = 8'h00;
          pos = pos + 1;
        end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin
        block_buf[pos] = 8'h00;
        pos = pos + 1;
      end
      for (int j = 0; j < 8; j++) block_buf[56+j] = bit_len[63-8*j -: 8];
      compress_block();
      for (int j = 0; j < DIGEST_WORDS; j++)
        digest_q.push_back('{word: hash_chain[j], idx: j[2:0], last: (j == DIGEST_WORDS - 1)});
      hash_restart();
    end
  endfunction

  // Idle length for either side: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic void queue_beat(logic k, logic [7:0] v, bit hold, bit steady);
    send_q.push_back('{kind: k, value: v, hold: hold, steady: steady});
  endfunction

  // A message of len random bytes followed by its finish beat. The byte field of the finish
  // beat is random too, since the hasher must ignore it.
  function automatic void queue_message(int len, bit hold, bit steady);
    for (int j = 0; j < len; j++)
      queue_beat(KIND_DATA, 8'($urandom), hold && (j == 0), steady);
    queue_beat(KIND_FINISH, 8'($urandom), hold && (len == 0), steady);
  endfunction

  // Driver. A new beat is put on the bus only when the bus is free: nothing offered yet, or
  // the current beat accepted at this edge. The predictor sees each beat as it is accepted.
  always @(posedge clk) begin
    bit          took;
    int unsigned owed_now;
    took     = item_valid && !item_stall;
    owed_now = words_owed;
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (took) begin
        absorb_beat(kind, data_byte);
        if (kind == KIND_FINISH) begin
          owed_now   = words_owed + DIGEST_WORDS;
          words_owed <= owed_now;
        end
      end
      if (!item_valid || took) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (send_q.size() != 0 && (!send_q[0].hold || owed_now == words_seen)) begin
          item_valid <= 1'b1;
          kind       <= send_q[0].kind;
          data_byte  <= send_q[0].value;
          gap_left   <= send_q[0].steady ? 0 : idle_len();
          void'(send_q.pop_front());
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted digest beat is checked against the oldest expected word.
  // Backpressure is random; after each complete digest the receiver may switch to a
  // stretch with no stalls at all.
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        words_seen <= words_seen + 1;
        if (digest_q.size() == 0) begin
          $error("unexpected digest beat: digest_word %h word_index %0d last %0b",
                 digest_word, word_index, last);
          fails++;
        end else begin
          want = digest_q.pop_front();
          if (digest_word !== want.word) begin
            $error("digest_word mismatch: expected %h, actual %h", want.word, digest_word);
            fails++;
          end
          if (word_index !== want.idx) begin
            $error("word_index mismatch: expected %0d, actual %0d", want.idx, word_index);
            fails++;
          end
          if (last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, last);
            fails++;
          end
          if (want.last) recv_steady = ($urandom_range(0, 3) == 0);
        end
      end
      if (stall_left != 0) begin
        result_stall <= 1'b1;
        stall_left   <= stall_left - 1;
      end else begin
        result_stall <= 1'b0;
        stall_left   <= recv_steady ? 0 : idle_len();
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int          r;
    int          len;
    int          msg_no;
    hash_restart();

    // Directed part: the empty message, single bytes at both extremes of the byte field,
    // and a short three-byte message whose finish beat carries an all-ones byte field.
    queue_beat(KIND_FINISH, 8'h00, 1'b0, 1'b1);
    queue_beat(KIND_DATA, 8'h00, 1'b0, 1'b1);
    queue_beat(KIND_FINISH, 8'h00, 1'b0, 1'b1);
    queue_beat(KIND_DATA, 8'hff, 1'b0, 1'b0);
    queue_beat(KIND_FINISH, 8'h00, 1'b0, 1'b0);
    queue_beat(KIND_DATA, 8'h61, 1'b0, 1'b0);
    queue_beat(KIND_DATA, 8'h62, 1'b0, 1'b0);
    queue_beat(KIND_DATA, 8'h63, 1'b0, 1'b0);
    queue_beat(KIND_FINISH, 8'hff, 1'b0, 1'b0);

    // Random messages. Lengths lean toward the padding boundaries: 55 bytes still fits the
    // length in the same block, 56 to 63 force a second padding block, and 64 or 128 end
    // exactly on a block so the finish pads a fresh one. Every fourth message first waits
    // for the hasher to drain all owed digest words. The last message is cut short so the
    // total stays at the beat target.
    msg_no = 0;
    while (send_q.size() < TARGET_BEATS) begin
      r = $urandom_range(0, 9);
      if (r < 4) len = $urandom_range(0, 12);
      else if (r < 7) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 128;
        endcase
      end else len = $urandom_range(13, 100);
      if (len > TARGET_BEATS - send_q.size() - 1) len = TARGET_BEATS - send_q.size() - 1;
      queue_message(len, (msg_no % 4) == 0, $urandom_range(0, 4) == 0);
      msg_no++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every beat to be sent and every owed digest word to come back, then give
    // the hasher time to show any stray output.
    do @(posedge clk);
    while (send_q.size() != 0 || item_valid || words_seen != words_owed ||
           digest_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every gap and stall at its longest.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
